@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker module of this project.
// Needs nothing else; each file that asserts includes it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define BMHQ_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("binary_min_heap_queue: assertion failed");

// Checked on every rising edge, reset included.
`define BMHQ_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("binary_min_heap_queue: assertion failed");

`endif

@@ rtl/core/bmhq_pkg.sv @@
// Package of the binary min-heap queue: sizes, command and status codes, states.
// Depends on nothing; used by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package bmhq_pkg;

  localparam int HeapDepth = 256;
  localparam int IdxW      = $clog2(HeapDepth);
  localparam int CntW      = IdxW + 1;
  localparam int KeyW      = 32;
  localparam int CapW      = 9;
  localparam int InIdxW    = 8;
  localparam int CmdW      = 2;
  localparam int StatW     = 2;
  localparam int CapReset  = 256;
  localparam int CmpW      = (CapW > CntW) ? CapW : CntW;
  localparam int DelCmpW   = (InIdxW > CntW) ? InIdxW : CntW;

  localparam logic [KeyW-1:0] KeyMostNeg  = {1'b1, {(KeyW-1){1'b0}}};
  localparam logic [KeyW-1:0] KeyMinusOne = {KeyW{1'b1}};

  typedef enum logic [CmdW-1:0] {
    CmdInsert  = 2'd0,
    CmdExtract = 2'd1,
    CmdDelete  = 2'd2,
    CmdNop     = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    StOk     = 2'd0,
    StFull   = 2'd1,
    StEmpty  = 2'd2,
    StBadIdx = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SUpRd,
    SUpCmp,
    SExRd,
    SExCmp,
    SDnRd,
    SDnCmp,
    SResp
  } state_e;

endpackage

`default_nettype wire

@@ rtl/core/binary_min_heap_queue.sv @@
// Binary min-heap queue of signed keys: one heap memory and one sift sequencer.
// Depends on bmhq_pkg.
//
// The block holds up to 256 signed 32-bit keys in an array heap and takes one
// transaction at a time: insert, extract minimum or delete at an array index.
// Each transaction yields exactly one result with the value, a status and the
// entry count. The heap memory has one write port and two registered read
// ports, and each level of a sift has a read state, which reads the parent or
// both children, and a compare state, which compares and writes back. A delete
// is a sift-up from its index followed by an extract. Refused transactions
// (full, empty or bad index) and the unused command go straight to the result.
// The capacity register may be written at any time the queue is idle and
// takes effect on the next insert.
`timescale 1ns / 1ps
`default_nettype none

module binary_min_heap_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bmhq_pkg::CapW-1:0]    cfg_capacity_limit_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [bmhq_pkg::CmdW-1:0]    command_i,
  input  logic [bmhq_pkg::KeyW-1:0]    key_value_i,
  input  logic [bmhq_pkg::InIdxW-1:0]  entry_index_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [bmhq_pkg::KeyW-1:0]    min_value_o,
  output logic [bmhq_pkg::StatW-1:0]   status_o,
  output logic [bmhq_pkg::CntW-1:0]    entry_count_o
);
  import bmhq_pkg::*;

  state_e                state_q, state_d;
  cmd_e                  op_q, op_d;
  status_e               status_q, status_d;
  logic [IdxW-1:0]       pos_q, pos_d;
  logic signed [KeyW-1:0] key_q, key_d;
  logic [KeyW-1:0]       min_q, min_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [CapW-1:0]       cap_q;

  logic [KeyW-1:0]       heap_mem_q [HeapDepth];
  logic signed [KeyW-1:0] rd_a_q, rd_b_q;
  logic                  we;
  logic [IdxW-1:0]       waddr, raddr_a, raddr_b;
  logic [KeyW-1:0]       wdata;

  logic [IdxW-1:0]       parent_idx, last_idx;
  logic [IdxW+1:0]       lchild, rchild;
  logic                  l_valid, r_valid, pick_l, pick_r, full;
  logic signed [KeyW-1:0] best_key;
  state_e                after_up;

  assign parent_idx = IdxW'((pos_q - IdxW'(1)) >> 1);
  assign last_idx   = IdxW'(cnt_q - CntW'(1));
  assign lchild     = {1'b0, pos_q, 1'b1};
  assign rchild     = {1'b0, pos_q, 1'b0} + (IdxW+2)'(2);
  assign l_valid    = lchild < (IdxW+2)'(cnt_q);
  assign r_valid    = rchild < (IdxW+2)'(cnt_q);
  assign pick_l     = l_valid && (rd_a_q < key_q);
  assign best_key   = pick_l ? rd_a_q : key_q;
  assign pick_r     = r_valid && (rd_b_q < best_key);
  assign full       = (CmpW'(cnt_q) >= CmpW'(cap_q)) || (CmpW'(cnt_q) >= CmpW'(HeapDepth));
  assign after_up   = (op_q == CmdDelete) ? SExRd : SResp;

  assign cfg_ready_o   = 1'b1;
  assign in_ready_o    = (state_q == SIdle);
  assign out_valid_o   = (state_q == SResp);
  assign min_value_o   = min_q;
  assign status_o      = status_q;
  assign entry_count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
      cap_q   <= CapW'(CapReset);
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_capacity_limit_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    status_q <= status_d;
    pos_q    <= pos_d;
    key_q    <= key_d;
    min_q    <= min_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      heap_mem_q[waddr] <= wdata;
    end
    rd_a_q <= heap_mem_q[raddr_a];
    rd_b_q <= heap_mem_q[raddr_b];
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    status_d = status_q;
    pos_d    = pos_q;
    key_d    = key_q;
    min_d    = min_q;
    cnt_d    = cnt_q;
    we       = 1'b0;
    waddr    = pos_q;
    wdata    = key_q;
    raddr_a  = parent_idx;
    raddr_b  = last_idx;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          op_d     = cmd_e'(command_i);
          status_d = StOk;
          min_d    = '0;
          case (cmd_e'(command_i))
            CmdInsert: begin
              if (full) begin
                status_d = StFull;
                state_d  = SResp;
              end else begin
                pos_d   = IdxW'(cnt_q);
                key_d   = key_value_i;
                cnt_d   = cnt_q + CntW'(1);
                state_d = SUpRd;
              end
            end
            CmdExtract: begin
              if (cnt_q == '0) begin
                status_d = StEmpty;
                min_d    = KeyMinusOne;
                state_d  = SResp;
              end else begin
                state_d = SExRd;
              end
            end
            CmdDelete: begin
              if (DelCmpW'(entry_index_i) >= DelCmpW'(cnt_q)) begin
                status_d = StBadIdx;
                state_d  = SResp;
              end else begin
                pos_d   = IdxW'(entry_index_i);
                key_d   = KeyMostNeg;
                state_d = SUpRd;
              end
            end
            default: begin
              state_d = SResp;
            end
          endcase
        end
      end
      SUpRd: begin
        if (pos_q == '0) begin
          we      = 1'b1;
          state_d = after_up;
        end else begin
          state_d = SUpCmp;
        end
      end
      SUpCmp: begin
        we = 1'b1;
        if (key_q < rd_a_q) begin
          wdata   = rd_a_q;
          pos_d   = parent_idx;
          state_d = SUpRd;
        end else begin
          state_d = after_up;
        end
      end
      SExRd: begin
        raddr_a = '0;
        state_d = SExCmp;
      end
      SExCmp: begin
        if (op_q == CmdExtract) begin
          min_d = rd_a_q;
        end
        key_d   = rd_b_q;
        cnt_d   = cnt_q - CntW'(1);
        pos_d   = '0;
        state_d = SDnRd;
      end
      SDnRd: begin
        raddr_a = lchild[IdxW-1:0];
        raddr_b = rchild[IdxW-1:0];
        if (l_valid) begin
          state_d = SDnCmp;
        end else begin
          we      = 1'b1;
          state_d = SResp;
        end
      end
      SDnCmp: begin
        we = 1'b1;
        if (pick_r) begin
          wdata   = rd_b_q;
          pos_d   = rchild[IdxW-1:0];
          state_d = SDnRd;
        end else if (pick_l) begin
          wdata   = rd_a_q;
          pos_d   = lchild[IdxW-1:0];
          state_d = SDnRd;
        end else begin
          state_d = SResp;
        end
      end
      SResp: begin
        if (out_ready_i) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/bmhq_checker.sv @@
// Port-level checker of the binary min-heap queue and its bind to the top level.
// Depends on bmhq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bmhq_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_o,
  input  logic                         out_valid_o,
  input  logic                         out_ready_i,
  input  logic [bmhq_pkg::KeyW-1:0]    min_value_o,
  input  logic [bmhq_pkg::StatW-1:0]   status_o,
  input  logic [bmhq_pkg::CntW-1:0]    entry_count_o
);
  import bmhq_pkg::*;

  // A result that is not taken holds its whole transaction.
  `BMHQ_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(min_value_o)
      && $stable(status_o) && $stable(entry_count_o))

  // The queue works on one transaction at a time.
  `BMHQ_ASSERT(a_busy_after_accept, clk_i, rst_ni,
    in_valid_i && in_ready_o |=> !in_ready_o)

  `BMHQ_ASSERT(a_no_overlap, clk_i, rst_ni, !(out_valid_o && in_ready_o))

  `BMHQ_ASSERT(a_count_bound, clk_i, rst_ni,
    out_valid_o |-> entry_count_o <= CntW'(HeapDepth))

  `BMHQ_ASSERT(a_empty_result, clk_i, rst_ni,
    out_valid_o && status_o == StEmpty |-> min_value_o == KeyMinusOne
      && entry_count_o == '0)

endmodule

bind binary_min_heap_queue bmhq_checker u_bmhq_checker (.*);

`default_nettype wire
